>>> src/motor_safety_interlock_assert.svh
// Assertion macros for the motor safety interlock.
// Both sample on the rising edge of i_clk, which must be in scope where they are used.
`ifndef MOTOR_SAFETY_INTERLOCK_ASSERT_SVH
`define MOTOR_SAFETY_INTERLOCK_ASSERT_SVH

// Checked only outside reset.
`define MSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define MSI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> src/msi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msi_pkg
// Shared types, mode codes and configuration constants of the motor safety
// interlock.
// ----------------------------------------------------------------------------
package msi_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_HALF_PERIOD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_PULSE_LENGTH = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FLASH_HALF_PERIOD_RST  = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] FAULT_PULSE_LENGTH_RST = 16'd500;

    localparam logic [1:0] MODE_NOT_READY = 2'd0;
    localparam logic [1:0] MODE_READY     = 2'd1;
    localparam logic [1:0] MODE_RUNNING   = 2'd2;

    typedef struct packed {
        logic start_button;
        logic stop_button;
        logic guard_switch;
        logic temp_switch;
    } t_pins;

    typedef struct packed {
        logic       motor_run;
        logic       ready_lamp;
        logic       temp_fault_lamp;
        logic       guard_fault_lamp;
        logic [1:0] mode_status;
    } t_result;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] flash_half_period;
        logic [CFG_DATA_W-1:0] fault_pulse_length;
    } t_cfg;

endpackage

>>> src/msi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msi_in_if
// Valid/ready channel carrying one pin sample per item.
// ----------------------------------------------------------------------------
interface msi_in_if;
    import msi_pkg::*;

    logic  valid;
    logic  ready;
    t_pins data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/msi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msi_out_if
// Valid/ready channel carrying one lamp and drive result per item.
// ----------------------------------------------------------------------------
interface msi_out_if;
    import msi_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/msi_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msi_cfg_regs
// Flash period and fault pulse length registers behind the write port.
// ----------------------------------------------------------------------------
module msi_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [msi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [msi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output msi_pkg::t_cfg                   o_cfg
);
    import msi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flash_half_period  <= FLASH_HALF_PERIOD_RST;
            r_cfg.fault_pulse_length <= FAULT_PULSE_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLASH_HALF_PERIOD:  r_cfg.flash_half_period  <= i_cfg_data;
                CFG_FAULT_PULSE_LENGTH: r_cfg.fault_pulse_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

>>> src/msi_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msi_core
// Edge detection, mode keeping, flash and fault pulse timers. Forms the
// result for the current sample and commits the new state on i_step.
// ----------------------------------------------------------------------------
module msi_core #(
    parameter int TIMER_BITS = msi_pkg::TIMER_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  msi_pkg::t_pins    i_pins,
    input  msi_pkg::t_cfg     i_cfg,
    output msi_pkg::t_result  o_result
);
    import msi_pkg::*;

    logic [1:0]            r_mode;
    t_pins                 r_prev;
    logic [TIMER_BITS-1:0] r_flash_count;
    logic                  r_flash_level;
    logic [TIMER_BITS-1:0] r_temp_count;
    logic [TIMER_BITS-1:0] r_guard_count;
    logic                  r_was_running;

    logic [1:0]            n_mode;
    logic [TIMER_BITS-1:0] n_flash_count;
    logic                  n_flash_level;
    logic [TIMER_BITS-1:0] n_temp_count;
    logic [TIMER_BITS-1:0] n_guard_count;
    logic                  n_was_running;

    logic [31:0]           w_period_wide;
    logic [31:0]           w_pulse_wide;
    logic [TIMER_BITS-1:0] w_period_raw;
    logic [TIMER_BITS-1:0] w_period;
    logic [TIMER_BITS-1:0] w_pulse;
    logic [TIMER_BITS-1:0] w_flash_inc;
    t_pins                 w_rise;
    logic                  w_fault_rise;
    logic                  w_temp_lit;
    logic                  w_guard_lit;
    logic                  w_lamp;

    // Keep only the low TIMER_BITS bits of each register (zero-extend when wider)
    assign w_period_wide = 32'(i_cfg.flash_half_period);
    assign w_pulse_wide  = 32'(i_cfg.fault_pulse_length);
    assign w_period_raw  = w_period_wide[TIMER_BITS-1:0];
    assign w_pulse       = w_pulse_wide[TIMER_BITS-1:0];
    assign w_period      = (w_period_raw == '0) ? TIMER_BITS'(1) : w_period_raw;

    assign w_rise       = i_pins & ~r_prev;
    assign w_fault_rise = w_rise.stop_button | w_rise.guard_switch | w_rise.temp_switch;
    assign w_flash_inc  = r_flash_count + TIMER_BITS'(1);

    always_comb begin
        n_mode        = r_mode;
        n_flash_count = r_flash_count;
        n_flash_level = r_flash_level;
        n_temp_count  = r_temp_count;
        n_guard_count = r_guard_count;
        n_was_running = r_was_running;

        if (w_fault_rise) begin
            if (r_mode != MODE_NOT_READY) begin
                n_flash_count = '0;
                n_flash_level = 1'b0;
            end
            n_mode = MODE_NOT_READY;
            if (w_rise.temp_switch) begin
                n_temp_count = w_pulse;
            end
            if (w_rise.guard_switch) begin
                if (r_was_running) begin
                    n_guard_count = w_pulse;
                end
                n_was_running = 1'b0;
            end
        end else if (r_mode == MODE_READY && w_rise.start_button) begin
            n_mode = MODE_RUNNING;
        end

        if (n_mode == MODE_NOT_READY &&
            !(i_pins.stop_button | i_pins.guard_switch | i_pins.temp_switch)) begin
            n_mode = MODE_READY;
        end

        w_lamp = n_flash_level;
        if (n_mode == MODE_READY) begin
            n_temp_count  = '0;
            n_guard_count = '0;
            w_lamp        = 1'b1;
        end else if (n_mode == MODE_RUNNING) begin
            n_was_running = 1'b1;
            w_lamp        = 1'b0;
        end else if (r_mode == MODE_NOT_READY) begin
            // Still not ready: advance the flash timer
            if (w_flash_inc >= w_period) begin
                n_flash_count = '0;
                n_flash_level = ~r_flash_level;
            end else begin
                n_flash_count = w_flash_inc;
            end
            w_lamp = n_flash_level;
        end

        w_temp_lit  = (n_temp_count != '0);
        w_guard_lit = (n_guard_count != '0);
        // Pulse timers count down after the lamps are taken
        if (w_temp_lit) begin
            n_temp_count = n_temp_count - TIMER_BITS'(1);
        end
        if (w_guard_lit) begin
            n_guard_count = n_guard_count - TIMER_BITS'(1);
        end
    end

    assign o_result.motor_run        = (n_mode == MODE_RUNNING);
    assign o_result.ready_lamp       = w_lamp;
    assign o_result.temp_fault_lamp  = w_temp_lit;
    assign o_result.guard_fault_lamp = w_guard_lit;
    assign o_result.mode_status      = n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_NOT_READY;
            r_prev        <= '0;
            r_flash_count <= '0;
            r_flash_level <= 1'b0;
            r_temp_count  <= '0;
            r_guard_count <= '0;
            r_was_running <= 1'b0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_prev        <= i_pins;
            r_flash_count <= n_flash_count;
            r_flash_level <= n_flash_level;
            r_temp_count  <= n_temp_count;
            r_guard_count <= n_guard_count;
            r_was_running <= n_was_running;
        end
    end
endmodule

>>> src/motor_safety_interlock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_safety_interlock
// Start/stop interlock with guard and over-temperature faults, flashing
// ready lamp and fault lamp pulses; one pin sample in, one result out.
// ----------------------------------------------------------------------------
//   channel    dir  handshake    payload
//   i_item     in   valid/ready  start, stop, guard, temp pin levels
//   o_result   out  valid/ready  motor_run, lamps, mode_status
//   i_cfg_*    in   write enable flash_half_period, fault_pulse_length
//
// From acceptance to result an item passes the input register, then the result register.
// One item per cycle sustained; the whole pipe holds while o_result stalls.
// Synchronous reset clears mode, timers, edge history and both valid flags;
// configuration returns to 2000 and 500 ticks.
// ----------------------------------------------------------------------------
module motor_safety_interlock #(
    parameter int TIMER_BITS = msi_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    msi_in_if.sink                          i_item,
    msi_out_if.source                       o_result,
    input  logic                            i_cfg_we,
    input  logic [msi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [msi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import msi_pkg::*;

    logic    r_in_valid;
    t_pins   r_in_pins;
    logic    r_out_valid;
    t_result r_out;

    logic    w_advance;
    logic    w_step;
    t_cfg    w_cfg;
    t_result w_result;

    assign w_advance    = !r_out_valid || o_result.ready;
    assign w_step       = r_in_valid && w_advance;
    assign i_item.ready = !r_in_valid || w_advance;

    msi_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    msi_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_pins   (r_in_pins),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_pins <= i_item.data;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
endmodule

>>> src/msi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msi_checker
// Port-level checks on the result channel of the motor safety interlock.
// ----------------------------------------------------------------------------
`include "motor_safety_interlock_assert.svh"

module msi_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  msi_pkg::t_result  i_out_data
);
    import msi_pkg::*;

    `MSI_ASSERT(a_run_matches_mode, i_out_valid |-> (i_out_data.motor_run == (i_out_data.mode_status == MODE_RUNNING)), "motor_run disagrees with mode")
    `MSI_ASSERT(a_ready_clears_faults, (i_out_valid && i_out_data.mode_status == MODE_READY) |-> (i_out_data.ready_lamp && !i_out_data.temp_fault_lamp && !i_out_data.guard_fault_lamp), "ready mode with dark lamp or lit fault lamp")
    `MSI_ASSERT(a_running_lamp_dark, (i_out_valid && i_out_data.mode_status == MODE_RUNNING) |-> !i_out_data.ready_lamp, "ready lamp lit while running")
    `MSI_ASSERT(a_stall_holds, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)), "stalled result changed")
endmodule

bind motor_safety_interlock msi_checker u_msi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

>>> bench/motor_safety_interlock_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_safety_interlock_tb
// Drives pin samples through the interlock and compares every result with
// a per-item model of the modes, the ready lamp flashing and the fault
// lamp pulses. Covers directed interlock sequences first, then randomised
// start/run/fault episodes mixed with pin noise. Timing settings change
// between phases, and both channels stall in random bursts.
// ----------------------------------------------------------------------------
module motor_safety_interlock_tb;
    import msi_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int NUM_PHASES  = 6;
    localparam int NUM_DIRECTED = 26;

    // {start, stop, guard, temp}
    localparam logic [3:0] DIRECTED_PINS [NUM_DIRECTED] = '{
        4'b0000, 4'b1000, 4'b1000, 4'b0000, 4'b0100, 4'b0100, 4'b0000,
        4'b1000, 4'b0010, 4'b0010, 4'b0000, 4'b0010, 4'b0000, 4'b1000,
        4'b0001, 4'b0000, 4'b1100, 4'b0000, 4'b1000, 4'b1111, 4'b1111,
        4'b0000, 4'b1001, 4'b1000, 4'b0000, 4'b1000
    };

    localparam logic [15:0] PHASE_FLASH [NUM_PHASES] = '{
        16'd1, 16'd0, 16'd65535, 16'd3, 16'd5, 16'd2
    };
    localparam logic [15:0] PHASE_PULSE [NUM_PHASES] = '{
        16'd1, 16'd0, 16'd65535, 16'd5, 16'd13, 16'd4
    };
    localparam int PHASE_IDLE  [NUM_PHASES] = '{40, 0, 25, 10, 50, 0};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{160, 160, 160, 160, 160, 150};

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    msi_in_if  item_if ();
    msi_out_if res_if ();

    motor_safety_interlock DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Interlock model state
    logic [15:0] flash_period_cfg = FLASH_HALF_PERIOD_RST;
    logic [15:0] pulse_len_cfg    = FAULT_PULSE_LENGTH_RST;
    logic [1:0]  mode_q    = MODE_NOT_READY;
    t_pins       last_pins = '0;
    logic [15:0] flash_cnt = '0;
    logic        flash_lvl = 1'b0;
    logic [15:0] temp_cnt  = '0;
    logic [15:0] guard_cnt = '0;
    logic        ran_since = 1'b0;

    t_pins   pin_queue [$];
    t_result lamp_queue [$];
    t_result want;
    int      queued_total = 0;
    int      fail_count   = 0;
    int      idle_pct     = 20;
    int      src_hold     = 0;
    int      snk_hold     = 0;
    int      stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic t_result interlock_tick(t_pins p);
        logic        rise_start, rise_stop, rise_guard, rise_temp;
        logic [1:0]  mode_was;
        logic [15:0] period;
        t_result     r;
        rise_start = p.start_button & ~last_pins.start_button;
        rise_stop  = p.stop_button  & ~last_pins.stop_button;
        rise_guard = p.guard_switch & ~last_pins.guard_switch;
        rise_temp  = p.temp_switch  & ~last_pins.temp_switch;
        last_pins  = p;
        mode_was   = mode_q;
        period     = (flash_period_cfg == '0) ? 16'd1 : flash_period_cfg;

        if (rise_stop | rise_guard | rise_temp) begin
            if (mode_q != MODE_NOT_READY) begin
                flash_cnt = '0;
                flash_lvl = 1'b0;
            end
            mode_q = MODE_NOT_READY;
            if (rise_temp)
                temp_cnt = pulse_len_cfg;
            if (rise_guard) begin
                // guard lamp only when the motor has run since the last one
                if (ran_since)
                    guard_cnt = pulse_len_cfg;
                ran_since = 1'b0;
            end
        end else if (mode_q == MODE_READY && rise_start) begin
            mode_q = MODE_RUNNING;
        end

        if (mode_q == MODE_NOT_READY && !(p.stop_button | p.guard_switch | p.temp_switch))
            mode_q = MODE_READY;

        r = '0;
        if (mode_q == MODE_READY) begin
            temp_cnt     = '0;
            guard_cnt    = '0;
            r.ready_lamp = 1'b1;
        end else if (mode_q == MODE_RUNNING) begin
            ran_since    = 1'b1;
            r.ready_lamp = 1'b0;
        end else begin
            // flash only advances on ticks that started in not ready
            if (mode_was == MODE_NOT_READY) begin
                flash_cnt = flash_cnt + 16'd1;
                if (flash_cnt >= period) begin
                    flash_cnt = '0;
                    flash_lvl = ~flash_lvl;
                end
            end
            r.ready_lamp = flash_lvl;
        end

        r.motor_run        = (mode_q == MODE_RUNNING);
        r.temp_fault_lamp  = (temp_cnt != '0);
        r.guard_fault_lamp = (guard_cnt != '0);
        r.mode_status      = mode_q;

        if (temp_cnt != '0)
            temp_cnt = temp_cnt - 16'd1;
        if (guard_cnt != '0)
            guard_cnt = guard_cnt - 16'd1;
        return r;
    endfunction

    // Driver: predict on acceptance, then offer the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            item_if.data  <= '0;
            src_hold      <= 0;
        end else begin
            if (item_if.valid && item_if.ready)
                lamp_queue.push_back(interlock_tick(item_if.data));
            if (!item_if.valid || item_if.ready) begin
                if (src_hold > 0) begin
                    src_hold      <= src_hold - 1;
                    item_if.valid <= 1'b0;
                end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    src_hold      <= $urandom_range(0, 4);
                    item_if.valid <= 1'b0;
                end else if (pin_queue.size() > 0) begin
                    item_if.valid <= 1'b1;
                    item_if.data  <= pin_queue.pop_front();
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            snk_hold     <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (lamp_queue.size() == 0) begin
                    $error("unexpected result %b", res_if.data);
                    fail_count++;
                end else begin
                    want = lamp_queue.pop_front();
                    if (res_if.data.motor_run !== want.motor_run) begin
                        $error("motor_run: expected %0b, got %0b",
                               want.motor_run, res_if.data.motor_run);
                        fail_count++;
                    end
                    if (res_if.data.ready_lamp !== want.ready_lamp) begin
                        $error("ready_lamp: expected %0b, got %0b",
                               want.ready_lamp, res_if.data.ready_lamp);
                        fail_count++;
                    end
                    if (res_if.data.temp_fault_lamp !== want.temp_fault_lamp) begin
                        $error("temp_fault_lamp: expected %0b, got %0b",
                               want.temp_fault_lamp, res_if.data.temp_fault_lamp);
                        fail_count++;
                    end
                    if (res_if.data.guard_fault_lamp !== want.guard_fault_lamp) begin
                        $error("guard_fault_lamp: expected %0b, got %0b",
                               want.guard_fault_lamp, res_if.data.guard_fault_lamp);
                        fail_count++;
                    end
                    if (res_if.data.mode_status !== want.mode_status) begin
                        $error("mode_status: expected %0d, got %0d",
                               want.mode_status, res_if.data.mode_status);
                        fail_count++;
                    end
                end
            end
            if (snk_hold > 0) begin
                snk_hold     <= snk_hold - 1;
                res_if.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                snk_hold     <= $urandom_range(0, 4);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_pins(t_pins p);
        pin_queue.push_back(p);
        queued_total++;
    endtask

    // Clear, start, run, fault, hold, with random timing and contents
    task automatic queue_episode();
        t_pins      p;
        logic [2:0] fault_bits;
        int         hold_len;
        repeat ($urandom_range(1, 3)) queue_pins('0);
        p = '0;
        p.start_button = 1'b1;
        repeat ($urandom_range(1, 3)) queue_pins(p);
        repeat ($urandom_range(1, 6)) begin
            p = '0;
            p.start_button = 1'($urandom_range(0, 1));
            queue_pins(p);
        end
        if ($urandom_range(0, 3) != 0)
            fault_bits = 3'b001 << $urandom_range(0, 2);
        else
            fault_bits = 3'($urandom_range(1, 7));
        hold_len = $urandom_range(1, 8);
        repeat (hold_len) begin
            p = '0;
            p.start_button = 1'($urandom_range(0, 1));
            {p.stop_button, p.guard_switch, p.temp_switch} =
                ($urandom_range(0, 4) == 0) ? fault_bits & 3'($urandom) : fault_bits;
            queue_pins(p);
        end
    endtask

    task automatic queue_random(int count);
        int target;
        target = queued_total + count;
        while (queued_total < target) begin
            if ($urandom_range(0, 3) != 0)
                queue_episode();
            else
                repeat ($urandom_range(1, 6)) queue_pins(t_pins'($urandom_range(0, 15)));
        end
    endtask

    // Wait until every item is accepted and every result has arrived
    task automatic drain();
        while (pin_queue.size() != 0 || item_if.valid || lamp_queue.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (4) @(posedge i_clk);
        #1;
    endtask

    task automatic set_timing(logic [15:0] flash, logic [15:0] pulse);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FLASH_HALF_PERIOD;
        cfg_data <= flash;
        @(posedge i_clk);
        cfg_idx  <= CFG_FAULT_PULSE_LENGTH;
        cfg_data <= pulse;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        #1;
        flash_period_cfg = flash;
        pulse_len_cfg    = pulse;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        #1;
        for (int i = 0; i < NUM_DIRECTED; i++)
            queue_pins(t_pins'(DIRECTED_PINS[i]));
        queue_random(150);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            set_timing(PHASE_FLASH[ph], PHASE_PULSE[ph]);
            idle_pct = PHASE_IDLE[ph];
            queue_random(PHASE_ITEMS[ph]);
        end
        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
